FILE: hw/rtl/tftk_pkg.sv
// Package: sizes, state encoding and register indexes for the token frequency tracker.
package tftk_pkg;

    localparam int VOCAB   = 1024;
    localparam int TOP_K   = 16;
    localparam int AW      = $clog2(VOCAB);
    localparam int CW      = AW + 1;
    localparam int KW      = $clog2(TOP_K + 1);
    localparam int KIW     = (TOP_K > 1) ? $clog2(TOP_K) : 1;
    localparam int FW      = 32;

    localparam logic [FW-1:0] ONE_Q16 = 32'h0001_0000;

    // Request modes
    localparam logic [1:0] MODE_TOKEN  = 2'd0;
    localparam logic [1:0] MODE_SELECT = 2'd1;
    localparam logic [1:0] MODE_QUERY  = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_VOCAB  = 2'd0;
    localparam logic [1:0] CFG_PERIOD = 2'd1;
    localparam logic [1:0] CFG_DECAY  = 2'd2;

    typedef enum logic [13:0] {
        S_IDLE   = 14'b00000000000001,
        S_PMOD   = 14'b00000000000010,
        S_CLR    = 14'b00000000000100,
        S_INC_RD = 14'b00000000001000,
        S_INC_WR = 14'b00000000010000,
        S_MAX    = 14'b00000000100000,
        S_NRM_RD = 14'b00000001000000,
        S_NRM_LD = 14'b00000010000000,
        S_NRM_DV = 14'b00000100000000,
        S_NRM_WR = 14'b00001000000000,
        S_DEC_RD = 14'b00010000000000,
        S_DEC_MU = 14'b00100000000000,
        S_DEC_WR = 14'b01000000000000,
        S_SEL    = 14'b10000000000000
    } t_state;

endpackage

FILE: hw/rtl/token_frequency_top_k_tracker_unit.sv
// Top level: token frequency table with batch normalization and top-K selection.
//
// A token request keeps busy high after it is accepted for the read and
// write of the frequency memory. The first token of a batch adds the batch
// phase check and, when the table is due for clearing, the clearing sweep. A
// request whose last flag is set then scans the table for its maximum and, if
// it is nonzero, divides every entry by it in a shared 1-bit-per-cycle
// restoring divider. A select request decays the table through one 32x16
// multiplier and then makes one pass over the tracked entries per selected
// index. A query is answered in the cycle after it is accepted. After reset
// the block clears the memory with busy high. Results appear on o_valid for
// exactly one cycle each and cannot be held off.
module token_frequency_top_k_tracker_unit
    import tftk_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_mode,
    input  logic signed [15:0] i_token,
    input  logic        i_last,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    output logic        o_valid,
    output logic [9:0]  o_index,
    output logic        o_active_flag,
    output logic        o_end_of_run
);

    t_state r_state;

    // Configuration
    logic [10:0] r_vocab;
    logic [15:0] r_period;
    logic [15:0] r_decay;

    // Batch state and active set
    logic [15:0]    r_phase;
    logic           r_in_batch;
    logic           r_all_act;
    logic [KW-1:0]  r_sel_cnt;
    logic [AW-1:0]  r_sel_idx [TOP_K];

    // Request working registers
    logic [AW-1:0]  r_tok;
    logic           r_tok_ok;
    logic           r_last;
    logic           r_clr_inc;
    logic [CW-1:0]  r_cnt;
    logic [AW-1:0]  r_pidx;
    logic           r_pend;
    logic [FW-1:0]  r_max;
    logic [FW:0]    r_rem;
    logic [16:0]    r_q;
    logic [3:0]     r_step;
    logic [FW-1:0]  r_prod;
    logic [KW-1:0]  r_k;
    logic [FW+AW-1:0] r_best;
    logic           r_found;
    logic [FW+AW-1:0] r_bound;
    logic           r_bval;

    // Frequency memory
    logic [FW-1:0]  mem [VOCAB];
    logic [FW-1:0]  r_rd;
    logic           mem_we;
    logic [AW-1:0]  mem_wa;
    logic [AW-1:0]  mem_ra;
    logic [FW-1:0]  mem_wd;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        r_rd <= mem[mem_ra];
    end

    // Tracked range and selection count
    logic [CW-1:0] n_trk;
    logic [KW-1:0] sel_count;
    assign n_trk     = (r_vocab > 11'(VOCAB)) ? CW'(VOCAB) : CW'(r_vocab);
    assign sel_count = (n_trk < CW'(TOP_K)) ? KW'(n_trk) : KW'(TOP_K);

    logic in_ok;
    assign in_ok = !i_token[15] && ({1'b0, i_token[14:0]} < 16'(n_trk));

    // Shared restoring divide step: batch phase modulo and normalization
    logic [15:0]  per_eff;
    logic [FW:0]  div;
    logic         in_bit;
    logic [FW:0]  rem_sh;
    logic         ge;
    logic [FW:0]  rem_nx;
    assign per_eff = (r_period == 16'd0) ? 16'd1 : r_period;
    assign div     = (r_state == S_NRM_DV) ? {1'b0, r_max} : {17'b0, per_eff};
    assign in_bit  = (r_state == S_PMOD) ? r_phase[r_step] : 1'b0;
    assign rem_sh  = {r_rem[FW-1:0], in_bit};
    assign ge      = (rem_sh >= div);
    assign rem_nx  = ge ? (rem_sh - div) : rem_sh;

    // Decay multiplier
    logic [47:0] prod;
    assign prod = r_rd * r_decay;

    // Scan issue and candidate compare
    logic [CW-1:0]     scan_lim;
    logic              issue;
    logic [FW+AW-1:0]  cand;
    logic              elig;
    assign scan_lim = (r_state == S_SEL) ? n_trk : CW'(VOCAB);
    assign issue    = (r_cnt < scan_lim);
    assign cand     = {r_rd, r_pidx};
    assign elig     = !r_bval || (cand < r_bound);

    // Query lookup against the selected set
    logic q_hit;
    always_comb begin
        q_hit = r_all_act;
        for (int j = 0; j < TOP_K; j++) begin
            if ((KW'(j) < r_sel_cnt) && (r_sel_idx[j] == i_token[AW-1:0])) begin
                q_hit = 1'b1;
            end
        end
    end

    // Memory port control
    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_cnt[AW-1:0];
        mem_wd = '0;
        mem_ra = r_cnt[AW-1:0];
        case (r_state)
            S_CLR: begin
                mem_we = 1'b1;
            end
            S_INC_RD: begin
                mem_ra = r_tok;
            end
            S_INC_WR: begin
                mem_we = r_tok_ok;
                mem_wa = r_tok;
                mem_wd = (r_rd[31:16] == 16'hFFFF) ? '1 : (r_rd + ONE_Q16);
            end
            S_NRM_WR: begin
                mem_we = 1'b1;
                mem_wd = {15'b0, r_q};
            end
            S_DEC_WR: begin
                mem_we = 1'b1;
                mem_wd = r_prod;
            end
            default: begin
            end
        endcase
    end

    assign busy = (r_state != S_IDLE);

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLR;
            r_vocab    <= 11'd1024;
            r_period   <= 16'd1000;
            r_decay    <= 16'd64881;
            r_phase    <= '0;
            r_in_batch <= 1'b0;
            r_all_act  <= 1'b1;
            r_sel_cnt  <= '0;
            r_cnt      <= '0;
            r_clr_inc  <= 1'b0;
            r_pend     <= 1'b0;
            o_valid    <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_VOCAB:  r_vocab  <= i_cfg_data[10:0];
                    CFG_PERIOD: r_period <= i_cfg_data;
                    CFG_DECAY:  r_decay  <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_tok    <= i_token[AW-1:0];
                        r_tok_ok <= in_ok;
                        r_last   <= i_last;
                        case (i_mode)
                            MODE_TOKEN: begin
                                if (!r_in_batch) begin
                                    r_in_batch <= 1'b1;
                                    r_rem      <= '0;
                                    r_step     <= 4'd15;
                                    r_state    <= S_PMOD;
                                end else begin
                                    r_state <= S_INC_RD;
                                end
                            end
                            MODE_SELECT: begin
                                r_all_act <= 1'b0;
                                r_sel_cnt <= sel_count;
                                r_cnt     <= '0;
                                r_state   <= S_DEC_RD;
                            end
                            MODE_QUERY: begin
                                o_valid       <= 1'b1;
                                o_index       <= in_ok ? i_token[AW-1:0] : '0;
                                o_active_flag <= in_ok && q_hit;
                                o_end_of_run  <= 1'b1;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_PMOD: begin
                    r_rem <= rem_nx;
                    if (r_step == 4'd0) begin
                        if (rem_nx == '0) begin
                            r_cnt     <= '0;
                            r_clr_inc <= 1'b1;
                            r_state   <= S_CLR;
                        end else begin
                            r_state <= S_INC_RD;
                        end
                    end else begin
                        r_step <= r_step - 4'd1;
                    end
                end
                S_CLR: begin
                    if (r_cnt == CW'(VOCAB - 1)) begin
                        r_state <= r_clr_inc ? S_INC_RD : S_IDLE;
                    end
                    r_cnt <= r_cnt + CW'(1);
                end
                S_INC_RD: begin
                    r_state <= S_INC_WR;
                end
                S_INC_WR: begin
                    if (r_last) begin
                        r_in_batch <= 1'b0;
                        r_phase    <= r_phase + 16'd1;
                        r_cnt      <= '0;
                        r_pend     <= 1'b0;
                        r_max      <= '0;
                        r_state    <= S_MAX;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_MAX: begin
                    r_pend <= issue;
                    if (issue) begin
                        r_cnt <= r_cnt + CW'(1);
                    end
                    if (r_pend && (r_rd > r_max)) begin
                        r_max <= r_rd;
                    end
                    if (!issue && !r_pend) begin
                        r_cnt   <= '0;
                        r_state <= (r_max == '0) ? S_IDLE : S_NRM_RD;
                    end
                end
                S_NRM_RD: begin
                    r_state <= S_NRM_LD;
                end
                S_NRM_LD: begin
                    r_rem   <= {1'b0, (r_rd >= r_max) ? (r_rd - r_max) : r_rd};
                    r_q     <= {16'b0, (r_rd >= r_max)};
                    r_step  <= 4'd15;
                    r_state <= S_NRM_DV;
                end
                S_NRM_DV: begin
                    r_rem <= rem_nx;
                    r_q   <= {r_q[15:0], ge};
                    if (r_step == 4'd0) begin
                        r_state <= S_NRM_WR;
                    end else begin
                        r_step <= r_step - 4'd1;
                    end
                end
                S_NRM_WR: begin
                    r_cnt   <= r_cnt + CW'(1);
                    r_state <= (r_cnt == CW'(VOCAB - 1)) ? S_IDLE : S_NRM_RD;
                end
                S_DEC_RD: begin
                    r_state <= S_DEC_MU;
                end
                S_DEC_MU: begin
                    r_prod  <= prod[47:16];
                    r_state <= S_DEC_WR;
                end
                S_DEC_WR: begin
                    if (r_cnt == CW'(VOCAB - 1)) begin
                        r_cnt   <= '0;
                        r_pend  <= 1'b0;
                        r_k     <= '0;
                        r_found <= 1'b0;
                        r_bval  <= 1'b0;
                        r_state <= (r_sel_cnt == '0) ? S_IDLE : S_SEL;
                    end else begin
                        r_cnt   <= r_cnt + CW'(1);
                        r_state <= S_DEC_RD;
                    end
                end
                S_SEL: begin
                    r_pend <= issue;
                    r_pidx <= r_cnt[AW-1:0];
                    if (issue) begin
                        r_cnt <= r_cnt + CW'(1);
                    end
                    if (r_pend && elig && (!r_found || (cand > r_best))) begin
                        r_best  <= cand;
                        r_found <= 1'b1;
                    end
                    // End of one pass: emit the best remaining entry
                    if (!issue && !r_pend) begin
                        o_valid          <= 1'b1;
                        o_index          <= r_best[AW-1:0];
                        o_active_flag    <= 1'b0;
                        o_end_of_run     <= (r_k + KW'(1) == r_sel_cnt);
                        r_sel_idx[r_k[KIW-1:0]] <= r_best[AW-1:0];
                        r_bound          <= r_best;
                        r_bval           <= 1'b1;
                        r_found          <= 1'b0;
                        r_k              <= r_k + KW'(1);
                        r_cnt            <= '0;
                        if (r_k + KW'(1) == r_sel_cnt) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Checks
    a_sel_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sel_cnt <= KW'(TOP_K))
        else $error("selected count above TOP_K");

    a_sel_k: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEL) |-> (r_k < r_sel_cnt))
        else $error("selection pass beyond count");

    a_div_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_NRM_DV) |-> (r_max != '0))
        else $error("normalizing by zero maximum");

    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> ($past(r_state) == S_SEL) || ($past(r_state) == S_IDLE))
        else $error("result outside select or query");

endmodule

FILE: tb/sv/tb.sv
// Testbench for the token frequency tracker: batch, select and query requests checked against a predictor.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import tftk_pkg::*;

    localparam int WATCHDOG_LIMIT = 100000;
    localparam int DRAIN_CYCLES   = 64;

    typedef struct packed {
        logic [9:0] index;
        logic       active;
        logic       eor;
    } t_top_result;

    // Tracks table state, predicts selections and query answers, checks results
    class top_k_scoreboard;
        logic [FW-1:0] freq [VOCAB];
        logic          mask [VOCAB];
        logic [15:0]   phase;
        logic          open_batch;
        logic [10:0]   vocab_cfg;
        logic [15:0]   period_cfg;
        logic [15:0]   decay_cfg;
        t_top_result   pending_q[$];
        int            errors;
        int            results_seen;
        int            selects;
        int            queries;
        int            tokens;

        function new();
            for (int i = 0; i < VOCAB; i++) begin
                freq[i] = '0;
                mask[i] = 1'b1;
            end
            phase = '0;
            open_batch = 1'b0;
            vocab_cfg = 11'd1024;
            period_cfg = 16'd1000;
            decay_cfg = 16'd64881;
            errors = 0;
            results_seen = 0;
            selects = 0;
            queries = 0;
            tokens = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [15:0] data);
            case (idx)
                CFG_VOCAB:  vocab_cfg = data[10:0];
                CFG_PERIOD: period_cfg = data;
                CFG_DECAY:  decay_cfg = data;
                default: ;
            endcase
        endfunction

        function int tracked_count();
            return (vocab_cfg > VOCAB) ? VOCAB : int'(vocab_cfg);
        endfunction

        // Called once per accepted request
        function void note_request(logic [1:0] mode, logic [15:0] token, logic last);
            int            n;
            logic          in_range;
            logic [FW-1:0] mx;
            logic [47:0]   scaled;
            logic [47:0]   prod;
            int            count;
            logic [FW-1:0] best;
            int            bidx;
            logic          found;
            t_top_result   r;
            n = tracked_count();
            in_range = !token[15] && (int'(token) < n);
            case (mode)
                MODE_TOKEN: begin
                    tokens++;
                    // batch open: clear when phase hits a multiple of the period
                    if (!open_batch) begin
                        open_batch = 1'b1;
                        if ((phase % ((period_cfg == 0) ? 16'd1 : period_cfg)) == 0)
                            for (int i = 0; i < VOCAB; i++) freq[i] = '0;
                    end
                    if (in_range)
                        freq[token] = (freq[token] > 32'hFFFF_FFFF - ONE_Q16) ?
                                      32'hFFFF_FFFF : freq[token] + ONE_Q16;
                    // batch close: advance phase, normalize to table maximum
                    if (last) begin
                        open_batch = 1'b0;
                        phase = phase + 16'd1;
                        mx = '0;
                        for (int i = 0; i < VOCAB; i++)
                            if (freq[i] > mx) mx = freq[i];
                        if (mx != 0)
                            for (int i = 0; i < VOCAB; i++) begin
                                scaled = {freq[i], 16'h0000} / {16'h0000, mx};
                                freq[i] = scaled[31:0];
                            end
                    end
                end
                MODE_SELECT: begin
                    selects++;
                    for (int i = 0; i < VOCAB; i++) begin
                        prod = {16'h0000, freq[i]} * {32'h0, decay_cfg};
                        freq[i] = prod[47:16];
                    end
                    for (int i = 0; i < VOCAB; i++) mask[i] = 1'b0;
                    count = (n < TOP_K) ? n : TOP_K;
                    // repeated max search, ties to the higher index
                    for (int k = 0; k < count; k++) begin
                        best = '0;
                        bidx = 0;
                        found = 1'b0;
                        for (int i = 0; i < n; i++)
                            if (!mask[i] && (!found || freq[i] >= best)) begin
                                best = freq[i];
                                bidx = i;
                                found = 1'b1;
                            end
                        mask[bidx] = 1'b1;
                        r.index = bidx[9:0];
                        r.active = 1'b0;
                        r.eor = (k + 1 == count);
                        pending_q = {pending_q, r};
                    end
                end
                MODE_QUERY: begin
                    queries++;
                    r.index = in_range ? token[9:0] : 10'd0;
                    r.active = in_range ? mask[token] : 1'b0;
                    r.eor = 1'b1;
                    pending_q = {pending_q, r};
                end
                default: ;
            endcase
        endfunction

        function void check_result(logic [9:0] index, logic active, logic eor);
            t_top_result e;
            results_seen++;
            if (pending_q.size() == 0) begin
                $display("%0t: unexpected result index=%0d active=%0b eor=%0b",
                         $time, index, active, eor);
                errors++;
                return;
            end
            e = pending_q.pop_front();
            if (index !== e.index) begin
                $display("%0t: index expected %0d actual %0d", $time, e.index, index);
                errors++;
            end
            if (active !== e.active) begin
                $display("%0t: active_flag expected %0b actual %0b", $time, e.active, active);
                errors++;
            end
            if (eor !== e.eor) begin
                $display("%0t: end_of_run expected %0b actual %0b", $time, e.eor, eor);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  i_mode;
    logic signed [15:0] i_token;
    logic        i_last;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [15:0] i_cfg_data;
    logic        o_valid;
    logic [9:0]  o_index;
    logic        o_active_flag;
    logic        o_end_of_run;

    top_k_scoreboard sb;
    int              quiet_cycles = 0;

    token_frequency_top_k_tracker_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_mode        (i_mode),
        .i_token       (i_token),
        .i_last        (i_last),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .o_valid       (o_valid),
        .o_index       (o_index),
        .o_active_flag (o_active_flag),
        .o_end_of_run  (o_end_of_run)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid)
            sb.check_result(o_index, o_active_flag, o_end_of_run);
    end

    // Watchdog on cycles with no request or result
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired", $time);
            $display("TB_ERROR");
            $finish;
        end
    end

    // Issue one request after a random gap; start stays high on return
    task automatic send_request(logic [1:0] mode, logic [15:0] token, logic last);
        int gap;
        gap = (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14));
        repeat (gap) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_mode <= mode;
        i_token <= token;
        i_last <= last;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        sb.note_request(mode, token, last);
    endtask

    // Wait until all results are in and the block is idle
    task automatic wait_idle();
        start <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_q.size() != 0 || busy) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_reg(idx, data);
    endtask

    // Random mix: well-formed batches, selects, queries and some noise
    task automatic random_traffic(int items);
        int   sent;
        int   len;
        int   n;
        int   pick;
        logic [15:0] tok;
        sent = 0;
        n = sb.tracked_count();
        while (sent < items) begin
            pick = $urandom_range(0, 99);
            if (pick < 62) begin
                len = $urandom_range(1, 10);
                for (int j = 0; j < len; j++) begin
                    if ($urandom_range(0, 9) == 0)
                        tok = 16'($urandom);
                    else
                        tok = 16'($urandom_range(0, n - 1));
                    send_request(MODE_TOKEN, tok, j == len - 1);
                end
                sent += len;
            end else if (pick < 70 && (n <= 64 || $urandom_range(0, 5) == 0)) begin
                send_request(MODE_SELECT, 16'($urandom), 1'($urandom));
                sent++;
            end else if (pick < 95) begin
                tok = ($urandom_range(0, 4) == 0) ? 16'($urandom)
                                                  : 16'($urandom_range(0, n - 1));
                send_request(MODE_QUERY, tok, 1'($urandom));
                sent++;
            end else begin
                send_request(2'd3, 16'($urandom), 1'($urandom));
            end
        end
    endtask

    initial begin
        sb = new();
        i_rst_n <= 1'b0;
        start <= 1'b0;
        i_mode <= MODE_TOKEN;
        i_token <= '0;
        i_last <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= CFG_VOCAB;
        i_cfg_data <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset mask, extremes, empty batch, mode 3, out-of-range ids
        send_request(MODE_QUERY, 16'd1023, 1'b0);
        send_request(MODE_QUERY, 16'd1024, 1'b0);
        send_request(MODE_QUERY, 16'hFFFF, 1'b1);
        send_request(MODE_TOKEN, 16'hFFFF, 1'b1);
        send_request(MODE_TOKEN, 16'd0, 1'b0);
        send_request(MODE_TOKEN, 16'd1023, 1'b0);
        send_request(MODE_TOKEN, 16'd1023, 1'b0);
        send_request(MODE_TOKEN, 16'd1024, 1'b0);
        send_request(MODE_TOKEN, 16'h8000, 1'b0);
        send_request(MODE_TOKEN, 16'h7FFF, 1'b0);
        send_request(2'd3, 16'd5, 1'b1);
        send_request(MODE_SELECT, 16'd0, 1'b0);
        send_request(MODE_TOKEN, 16'd7, 1'b1);
        send_request(MODE_QUERY, 16'd1023, 1'b0);
        send_request(MODE_QUERY, 16'd5, 1'b0);
        wait_idle();

        // Smallest vocabulary, clear every batch, full decay to zero
        write_reg(CFG_VOCAB, 16'd16);
        write_reg(CFG_PERIOD, 16'd0);
        write_reg(CFG_DECAY, 16'd0);
        send_request(MODE_TOKEN, 16'd15, 1'b0);
        send_request(MODE_TOKEN, 16'd16, 1'b1);
        send_request(MODE_SELECT, 16'd0, 1'b0);
        send_request(MODE_QUERY, 16'd15, 1'b0);
        send_request(MODE_QUERY, 16'd16, 1'b0);
        wait_idle();
        write_reg(CFG_PERIOD, 16'd1);
        random_traffic(40);
        wait_idle();

        // Mid vocabulary, short period, near-unity decay
        write_reg(CFG_VOCAB, 16'd40);
        write_reg(CFG_PERIOD, 16'd3);
        write_reg(CFG_DECAY, 16'hFFFF);
        random_traffic(45);
        wait_idle();

        // Full vocabulary, longest period, random decay
        write_reg(CFG_VOCAB, 16'd1024);
        write_reg(CFG_PERIOD, 16'hFFFF);
        write_reg(CFG_DECAY, 16'($urandom_range(30000, 65535)));
        random_traffic(30);
        wait_idle();

        $display("Covered %0d token, %0d select and %0d query requests; %0d results checked.",
                 sb.tokens, sb.selects, sb.queries, sb.results_seen);
        $display("Vocab sizes 1024/16/40, periods 0/1/3/1000/65535, decay 0 to 65535.");
        if (sb.errors == 0 && sb.pending_q.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

FILE: filelist.f
hw/rtl/tftk_pkg.sv
hw/rtl/token_frequency_top_k_tracker_unit.sv
tb/sv/tb.sv
